### rtl/smt_pkg.sv
package smt_pkg;

    // operation codes (s_tuser)
    localparam logic [2:0] OP_OBSERVE  = 3'd0;
    localparam logic [2:0] OP_SELECT   = 3'd1;
    localparam logic [2:0] OP_DESELECT = 3'd2;
    localparam logic [2:0] OP_REMOVE   = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    // status codes (m_tuser)
    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // one table entry as held in the entry RAM
    typedef struct packed {
        logic [47:0] addr;
        logic [31:0] count;
        logic [31:0] seen;
        logic [7:0]  ap;
        logic [3:0]  chan;
    } entry_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic start;
        logic vld;
    } scan_ctl_t;

endpackage

### rtl/smt_entry_ram.sv
module smt_entry_ram #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  smt_pkg::entry_t    wdata,
    input  logic               re,
    input  logic [IDX_W-1:0]   raddr,
    output smt_pkg::entry_t    rdata
);

    smt_pkg::entry_t mem [DEPTH];

    // single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/smt_scan_unit.sv
module smt_scan_unit #(
    parameter int IDX_W = 6
) (
    input  logic               aclk,
    input  smt_pkg::scan_ctl_t ctl,
    input  logic [IDX_W-1:0]   cmp_idx,
    input  smt_pkg::entry_t    entry,
    input  logic [47:0]        key,
    output logic               hit,
    output logic [IDX_W-1:0]   min_idx
);

    logic [31:0]      min_seen_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic             first_reg;
    logic             take;

    // address match on the entry just read
    assign hit = ctl.vld && (entry.addr == key);

    // strict less-than keeps the lowest index on a tie
    assign take = ctl.vld && (first_reg || (entry.seen < min_seen_reg));

    // running minimum of last-seen time over the scan
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            first_reg <= 1'b1;
        end else if (ctl.vld) begin
            first_reg <= 1'b0;
        end
        if (take) begin
            min_seen_reg <= entry.seen;
            min_idx_reg  <= cmp_idx;
        end
    end

    assign min_idx = min_idx_reg;

endmodule

### rtl/station_mac_table_with_eviction.sv
// Observe reads the valid entries in order, one RAM read per cycle, until an address hit;
// on a miss it appends, and on a full table it first compacts out the least-recent entry.
// Remove compacts the entries above the index; other operations go straight to the result.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous): table empty, select flags and counts cleared,
// no result pending. Entry RAM is not cleared; only written entries are ever read.
module station_mac_table_with_eviction #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation
    input  logic [2:0]   s_tuser,
    // station_address[47:0], ap_index[55:48], channel[59:56], now[91:60],
    // entry_index[97:92], zero pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status
    output logic [1:0]   m_tuser,
    // result_index[5:0], packet_count[37:6], table_count[44:38],
    // selected_count[51:45], evicted[52], zero pad
    output logic [55:0]  m_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (CNT_W > 6) ? CNT_W : 6;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [47:0]            key_reg, key_next;
    logic [7:0]             ap_reg, ap_next;
    logic [3:0]             chan_reg, chan_next;
    logic [31:0]            now_reg, now_next;
    logic [CNT_W-1:0]       valid_reg, valid_next;
    logic [CNT_W-1:0]       selcnt_reg, selcnt_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       at_reg, at_next;
    logic [TABLE_DEPTH-1:0] sel_reg, sel_next, sel_shifted;
    logic [1:0]             rstat_reg, rstat_next;
    logic [IDX_W-1:0]       ridx_reg, ridx_next;
    logic [31:0]            rcnt_reg, rcnt_next;
    logic                   evict_reg, evict_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;
    logic [55:0]            m_tdata_reg, m_tdata_next;

    logic                   we, re;
    logic [IDX_W-1:0]       waddr, raddr, shift_pos;
    smt_pkg::entry_t        wdata, rdata;
    smt_pkg::scan_ctl_t     scan_ctl;
    logic                   hit;
    logic [IDX_W-1:0]       min_idx;

    logic [5:0]             in_eidx;
    logic [IDX_W-1:0]       in_tidx;
    logic                   in_range;

    assign in_eidx  = s_tdata[97:92];
    assign in_tidx  = IDX_W'(in_eidx);
    assign in_range = CW'(in_eidx) < CW'(valid_reg);

    smt_entry_ram #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    smt_scan_unit #(.IDX_W(IDX_W)) u_scan (
        .aclk    (aclk),
        .ctl     (scan_ctl),
        .cmp_idx (at_reg),
        .entry   (rdata),
        .key     (key_reg),
        .hit     (hit),
        .min_idx (min_idx)
    );

    // flag compaction from shift_pos upwards; the top flag empties
    always_comb begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (IDX_W'(j) >= shift_pos) begin
                sel_shifted[j] = (j == TABLE_DEPTH - 1) ? 1'b0 : sel_reg[(j + 1) % TABLE_DEPTH];
            end else begin
                sel_shifted[j] = sel_reg[j];
            end
        end
    end

    assign shift_pos = (state_reg == S_IDLE) ? in_tidx : min_idx;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        ap_next       = ap_reg;
        chan_next     = chan_reg;
        now_next      = now_reg;
        valid_next    = valid_reg;
        selcnt_next   = selcnt_reg;
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        at_next       = at_reg;
        sel_next      = sel_reg;
        rstat_next    = rstat_reg;
        ridx_next     = ridx_reg;
        rcnt_next     = rcnt_reg;
        evict_next    = evict_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        we            = 1'b0;
        waddr         = at_reg;
        wdata         = rdata;
        re            = 1'b0;
        raddr         = ptr_reg[IDX_W-1:0];
        scan_ctl      = '{start: 1'b0, vld: 1'b0};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[47:0];
                    ap_next    = s_tdata[55:48];
                    chan_next  = s_tdata[59:56];
                    now_next   = s_tdata[91:60];
                    rstat_next = smt_pkg::ST_DONE;
                    ridx_next  = '0;
                    rcnt_next  = '0;
                    evict_next = 1'b0;
                    state_next = S_DONE;
                    unique case (s_tuser) inside
                        smt_pkg::OP_OBSERVE: begin
                            ptr_next       = '0;
                            scan_ctl.start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        smt_pkg::OP_SELECT, smt_pkg::OP_DESELECT, smt_pkg::OP_REMOVE: begin
                            if (!in_range) begin
                                rstat_next = smt_pkg::ST_RANGE;
                            end else if (s_tuser == smt_pkg::OP_SELECT) begin
                                if (!sel_reg[in_tidx]) begin
                                    selcnt_next = selcnt_reg + 1'b1;
                                end
                                sel_next[in_tidx] = 1'b1;
                            end else if (s_tuser == smt_pkg::OP_DESELECT) begin
                                if (sel_reg[in_tidx]) begin
                                    selcnt_next = selcnt_reg - 1'b1;
                                end
                                sel_next[in_tidx] = 1'b0;
                            end else begin
                                selcnt_next = selcnt_reg - CNT_W'(sel_reg[in_tidx]);
                                sel_next    = sel_shifted;
                                ptr_next    = CNT_W'(in_tidx) + 1'b1;
                                state_next  = S_SHIFT;
                            end
                        end
                        smt_pkg::OP_CLEAR: begin
                            valid_next  = '0;
                            selcnt_next = '0;
                            sel_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                scan_ctl.vld = pend_reg;
                if (hit) begin
                    // refresh the matching entry in place
                    we         = 1'b1;
                    wdata      = rdata;
                    wdata.count = rdata.count + 32'd1;
                    wdata.seen = now_reg;
                    rstat_next = smt_pkg::ST_UPDATED;
                    ridx_next  = at_reg;
                    rcnt_next  = rdata.count + 32'd1;
                    state_next = S_DONE;
                end else if (ptr_reg < valid_reg) begin
                    re        = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                    at_next   = ptr_reg[IDX_W-1:0];
                end else if (!pend_reg) begin
                    if (valid_reg == CNT_W'(TABLE_DEPTH)) begin
                        // evict the least-recent entry, then append
                        evict_next  = 1'b1;
                        selcnt_next = selcnt_reg - CNT_W'(sel_reg[min_idx]);
                        sel_next    = sel_shifted;
                        ptr_next    = CNT_W'(min_idx) + 1'b1;
                        state_next  = S_SHIFT;
                    end else begin
                        state_next = S_APPEND;
                    end
                end
            end

            S_SHIFT: begin
                // read entry i+1, write it back at i on the next cycle
                if (pend_reg) begin
                    we    = 1'b1;
                    wdata = rdata;
                end
                if (ptr_reg < valid_reg) begin
                    re        = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                    at_next   = IDX_W'(ptr_reg - 1'b1);
                end else if (!pend_reg) begin
                    valid_next = valid_reg - 1'b1;
                    state_next = (op_reg == smt_pkg::OP_OBSERVE) ? S_APPEND : S_DONE;
                end
            end

            S_APPEND: begin
                we         = 1'b1;
                waddr      = valid_reg[IDX_W-1:0];
                wdata      = '{addr: key_reg, count: 32'd1, seen: now_reg,
                               ap: ap_reg, chan: chan_reg};
                valid_next = valid_reg + 1'b1;
                rstat_next = smt_pkg::ST_NEW;
                ridx_next  = valid_reg[IDX_W-1:0];
                rcnt_next  = 32'd1;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = rstat_reg;
                    m_tdata_next  = {3'b000, evict_reg, 7'(selcnt_reg), 7'(valid_reg),
                                     rcnt_reg, 6'(ridx_reg)};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            selcnt_reg   <= '0;
            sel_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            selcnt_reg   <= selcnt_next;
            sel_reg      <= sel_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        ap_reg      <= ap_next;
        chan_reg    <= chan_next;
        now_reg     <= now_next;
        ptr_reg     <= ptr_next;
        at_reg      <= at_next;
        rstat_reg   <= rstat_next;
        ridx_reg    <= ridx_next;
        rcnt_reg    <= rcnt_next;
        evict_reg   <= evict_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_valid_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_selcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        selcnt_reg <= valid_reg)
        else $error("selected count exceeds entry count");

    a_flags_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (sel_reg >> valid_reg) == '0)
        else $error("select flag set beyond valid entries");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[52]) |-> (m_tdata[44:38] == 7'(TABLE_DEPTH)))
        else $error("eviction reported without a full table");
`endif

endmodule

### sim/station_mac_table_with_eviction_tb.sv
`timescale 1ns / 1ps

module station_mac_table_with_eviction_tb;

    localparam int DEPTH = 64;
    localparam int N_RANDOM = 668;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [2:0]   s_tuser;      // operation
    logic [103:0] s_tdata;      // address, ap, channel, now, entry index, pad
    logic         m_tvalid;
    logic         m_tready;
    logic [1:0]   m_tuser;      // status
    logic [55:0]  m_tdata;      // index, count, table count, selected count, evicted, pad

    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] addr;
        logic [7:0]  ap;
        logic [3:0]  chan;
        logic [31:0] now;
        logic [5:0]  idx;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [31:0] pkts;
        logic [6:0]  stations;
        logic [6:0]  selected;
        logic        evicted;
    } resp_t;

    // shadow copy of the station table
    logic [47:0] sh_addr [DEPTH];
    logic [31:0] sh_count[DEPTH];
    logic [31:0] sh_seen [DEPTH];
    logic        sh_sel  [DEPTH];
    int          sh_used;

    resp_t       pending_resp[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_evict;
    int          n_hits;
    logic [47:0] addr_pool[16];

    station_mac_table_with_eviction #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20ms;
        $display("timeout after %0d of %0d results", n_checked, n_sent);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("%t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    function automatic void drop_station(int pos);
        for (int i = pos; i + 1 < sh_used; i++) begin
            sh_addr[i]  = sh_addr[i+1];
            sh_count[i] = sh_count[i+1];
            sh_seen[i]  = sh_seen[i+1];
            sh_sel[i]   = sh_sel[i+1];
        end
        sh_used--;
        sh_sel[sh_used] = 1'b0;
    endfunction

    // updates the shadow table and returns the response it implies
    function automatic resp_t learn_station(req_t r);
        resp_t o;
        int    hit;
        int    oldest;
        o = '0;
        o.status = smt_pkg::ST_DONE;
        hit = -1;
        if (r.op == smt_pkg::OP_OBSERVE) begin
            for (int i = 0; i < sh_used; i++)
                if (hit < 0 && sh_addr[i] == r.addr) hit = i;
            if (hit >= 0) begin
                sh_count[hit] = sh_count[hit] + 1;
                sh_seen[hit]  = r.now;
                o.status = smt_pkg::ST_UPDATED;
                o.index  = 6'(hit);
                o.pkts   = sh_count[hit];
            end else begin
                if (sh_used >= DEPTH) begin
                    oldest = 0;
                    for (int i = 1; i < sh_used; i++)
                        if (sh_seen[i] < sh_seen[oldest]) oldest = i;
                    drop_station(oldest);
                    o.evicted = 1'b1;
                end
                sh_addr[sh_used]  = r.addr;
                sh_count[sh_used] = 1;
                sh_seen[sh_used]  = r.now;
                sh_sel[sh_used]   = 1'b0;
                o.status = smt_pkg::ST_NEW;
                o.index  = 6'(sh_used);
                o.pkts   = 1;
                sh_used++;
            end
        end else if (r.op == smt_pkg::OP_SELECT || r.op == smt_pkg::OP_DESELECT ||
                     r.op == smt_pkg::OP_REMOVE) begin
            if (r.idx >= sh_used) o.status = smt_pkg::ST_RANGE;
            else if (r.op == smt_pkg::OP_SELECT) sh_sel[r.idx] = 1'b1;
            else if (r.op == smt_pkg::OP_DESELECT) sh_sel[r.idx] = 1'b0;
            else drop_station(r.idx);
        end else if (r.op == smt_pkg::OP_CLEAR) begin
            sh_used = 0;
            for (int i = 0; i < DEPTH; i++) sh_sel[i] = 1'b0;
        end
        o.stations = 7'(sh_used);
        for (int i = 0; i < sh_used; i++) o.selected += sh_sel[i];
        return o;
    endfunction

    // one transfer in; idle gap first, tvalid stays up when there is no gap
    task automatic send(input req_t r);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pending_resp.push_back(learn_station(r));
        s_tuser  <= r.op;
        s_tdata  <= {6'd0, r.idx, r.now, r.chan, r.ap, r.addr};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    function automatic req_t blank(logic [2:0] op);
        req_t r;
        r = '0;
        r.op = op;
        return r;
    endfunction

    function automatic req_t observe(logic [47:0] a, logic [31:0] t);
        req_t r;
        r = blank(smt_pkg::OP_OBSERVE);
        r.addr = a;
        r.now  = t;
        r.ap   = 8'($urandom);
        r.chan = 4'($urandom_range(0, 14));
        return r;
    endfunction

    function automatic req_t by_index(logic [2:0] op, logic [5:0] i);
        req_t r;
        r = blank(op);
        r.idx  = i;
        r.addr = 48'({$urandom, $urandom});
        r.now  = $urandom;
        return r;
    endfunction

    // result side: random stall, then check against the oldest expectation
    initial begin
        resp_t got, want;
        int    stall;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0 && stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready && aresetn));
            got = {m_tuser, m_tdata[5:0], m_tdata[37:6], m_tdata[44:38], m_tdata[51:45],
                   m_tdata[52]};
            if (pending_resp.size() == 0) begin
                errors++;
                $display("%t unexpected result transfer", $realtime);
            end else begin
                want = pending_resp.pop_front();
                n_checked++;
                if (want.evicted) n_evict++;
                if (want.status == smt_pkg::ST_UPDATED) n_hits++;
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.index != want.index) report("result_index", got.index, want.index);
                if (got.pkts != want.pkts) report("packet_count", got.pkts, want.pkts);
                if (got.stations != want.stations)
                    report("table_count", got.stations, want.stations);
                if (got.selected != want.selected)
                    report("selected_count", got.selected, want.selected);
                if (got.evicted != want.evicted)
                    report("evicted", got.evicted, want.evicted);
            end
        end
    end

    // stimulus
    initial begin
        req_t  dir_tab[$];
        resp_t dir_want[$];
        req_t  r;
        int    k;
        int    mode;
        errors = 0; n_sent = 0; n_checked = 0; n_evict = 0; n_hits = 0;
        sh_used = 0;
        for (int i = 0; i < DEPTH; i++) sh_sel[i] = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; each row's expected response is checked against the predictor
        dir_tab.push_back(by_index(smt_pkg::OP_SELECT, 6'd0));
        dir_want.push_back({smt_pkg::ST_RANGE, 6'd0, 32'd0, 7'd0, 7'd0, 1'b0});
        dir_tab.push_back(by_index(smt_pkg::OP_REMOVE, 6'd63));
        dir_want.push_back({smt_pkg::ST_RANGE, 6'd0, 32'd0, 7'd0, 7'd0, 1'b0});
        dir_tab.push_back(observe(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        dir_want.push_back({smt_pkg::ST_NEW, 6'd0, 32'd1, 7'd1, 7'd0, 1'b0});
        dir_tab.push_back(observe(48'h0, 32'h0));
        dir_want.push_back({smt_pkg::ST_NEW, 6'd1, 32'd1, 7'd2, 7'd0, 1'b0});
        dir_tab.push_back(observe(48'hFFFF_FFFF_FFFF, 32'h1));
        dir_want.push_back({smt_pkg::ST_UPDATED, 6'd0, 32'd2, 7'd2, 7'd0, 1'b0});
        dir_tab.push_back(by_index(smt_pkg::OP_SELECT, 6'd1));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd2, 7'd1, 1'b0});
        dir_tab.push_back(by_index(smt_pkg::OP_SELECT, 6'd2));
        dir_want.push_back({smt_pkg::ST_RANGE, 6'd0, 32'd0, 7'd2, 7'd1, 1'b0});
        dir_tab.push_back(by_index(smt_pkg::OP_DESELECT, 6'd1));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd2, 7'd0, 1'b0});
        dir_tab.push_back(by_index(3'd5, 6'd0));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd2, 7'd0, 1'b0});
        dir_tab.push_back(by_index(3'd7, 6'd63));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd2, 7'd0, 1'b0});
        dir_tab.push_back(by_index(smt_pkg::OP_SELECT, 6'd1));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd2, 7'd1, 1'b0});
        dir_tab.push_back(by_index(smt_pkg::OP_REMOVE, 6'd0));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd1, 7'd1, 1'b0});
        dir_tab.push_back(by_index(smt_pkg::OP_CLEAR, 6'd0));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd0, 7'd0, 1'b0});
        dir_tab.push_back(observe(48'h5555_AAAA_5555, 32'h8000_0000));
        dir_want.push_back({smt_pkg::ST_NEW, 6'd0, 32'd1, 7'd1, 7'd0, 1'b0});
        dir_tab.push_back(by_index(3'd6, 6'd21));
        dir_want.push_back({smt_pkg::ST_DONE, 6'd0, 32'd0, 7'd1, 7'd0, 1'b0});
        foreach (dir_tab[i]) begin
            send(dir_tab[i]);
            if (pending_resp[$] != dir_want[i]) begin
                errors++;
                $display("directed row %0d disagrees with predictor", i);
            end
        end

        // fill to full with tied times, then overflow to force eviction with ties
        for (int i = 1; i < DEPTH; i++)
            send(observe({16'hA5A5, 32'(i)}, (i % 3 == 0) ? 32'd7 : 32'd100 + i));
        send(by_index(smt_pkg::OP_SELECT, 6'd63));
        send(observe(48'h1234_5678_9ABC, 32'd5000));
        send(observe(48'h1234_5678_9ABC, 32'd5001));
        send(by_index(smt_pkg::OP_REMOVE, 6'd63));

        // random part: a small address pool makes hits, evictions and wraps likely
        for (int i = 0; i < 16; i++) addr_pool[i] = 48'({$urandom, $urandom});
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 250 == 0)
                for (int i = 0; i < 16; i++) addr_pool[i] = 48'({$urandom, $urandom});
            mode = $urandom_range(0, 99);
            if (mode < 55) begin
                k = $urandom_range(0, 99);
                if (k < 50) r = observe(addr_pool[$urandom_range(0, 15)], $urandom);
                else r = observe(48'({$urandom, $urandom}), $urandom_range(0, 40));
            end else if (mode < 90) begin
                r = by_index(3'($urandom_range(smt_pkg::OP_SELECT, smt_pkg::OP_REMOVE)),
                             ($urandom_range(0, 4) == 0) ? 6'($urandom) :
                             6'($urandom_range(0, (sh_used > 0) ? sh_used - 1 : 0)));
            end else if (mode < 94) begin
                r = by_index(smt_pkg::OP_CLEAR, 6'($urandom));
            end else begin
                r = by_index(3'($urandom_range(5, 7)), 6'($urandom));
            end
            send(r);
        end
        s_tvalid <= 1'b0;

        // wait for the last result, then a margin for the longest pass
        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (3 * DEPTH + 20) @(posedge aclk);
        $display("%0d transfers in, %0d results checked", n_sent, n_checked);
        $display("covered %0d hits and %0d evictions", n_hits, n_evict);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
